[rtl/dfa_pkg.sv]
// shared types, constants and helpers of the prefix matcher
package dfa_pkg;

	localparam int unsigned NUM_STATES = 16;
	localparam int unsigned MAX_LENGTH = 4095;
	localparam int unsigned NUM_SYMBOLS = 256;

	localparam int unsigned STATE_W = 4;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned LEN_W = 12;
	localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int unsigned FLAG_AW = $clog2(NUM_STATES);

	localparam int unsigned TAB_DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int unsigned TAB_AW = $clog2(TAB_DEPTH);

	localparam logic [1:0] OP_WR_EDGE = 2'd0;
	localparam logic [1:0] OP_WR_ACCEPT = 2'd1;
	localparam logic [1:0] OP_FEED = 2'd2;

	typedef struct packed {
		logic valid;
		logic [STATE_W-1:0] next;
	} edge_t;

	typedef struct packed {
		logic en;
		logic we;
		logic [TAB_AW-1:0] addr;
		edge_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [CNT_W-1:0] count;
		logic stopped;
	} run_t;

	typedef struct packed {
		logic valid;
		logic last;
	} s1_stat_t;

	typedef struct packed {
		logic accepted;
		logic [LEN_W-1:0] match_length;
	} result_t;

	function automatic logic in_range(input logic [STATE_W-1:0] s);
		return 32'(s) < NUM_STATES;
	endfunction

	function automatic logic [TAB_AW-1:0] tab_addr(input logic [STATE_W-1:0] s,
			input logic [SYM_W-1:0] sym);
		return TAB_AW'(32'(s) * NUM_SYMBOLS + 32'(sym));
	endfunction

endpackage

[rtl/dfa_trans_mem.sv]
// transition table memory with its clearing pass after reset
module dfa_trans_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  dfa_pkg::mem_req_t req,
	output dfa_pkg::edge_t   rdata,
	output logic             busy
);
	import dfa_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} mem_state_t;

	mem_state_t state_q;
	logic [TAB_AW-1:0] clr_addr_q;
	edge_t mem [TAB_DEPTH];

	logic wr_en;
	logic [TAB_AW-1:0] wr_addr;
	edge_t wr_data;

	assign busy = (state_q == ST_CLEAR);

	always_comb begin
		wr_en = busy | (req.en & req.we);
		wr_addr = busy ? clr_addr_q : req.addr;
		wr_data = busy ? '0 : req.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == TAB_AW'(TAB_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// single address per cycle: a write or a read, never both
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.en & ~req.we & ~busy) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

[rtl/dfa_walk.sv]
// run state, accepting flags and the lookup resolve stage
module dfa_walk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         issue,
	input  logic                         issue_last,
	input  logic [dfa_pkg::STATE_W-1:0]  issue_cur,
	input  logic                         advance,
	input  logic                         flag_we,
	input  logic [dfa_pkg::STATE_W-1:0]  flag_idx,
	input  logic                         flag_val,
	input  logic [dfa_pkg::STATE_W-1:0]  start_state,
	input  dfa_pkg::edge_t               rd,
	output dfa_pkg::run_t                fwd,
	output dfa_pkg::s1_stat_t            s1,
	output dfa_pkg::result_t             res
);
	import dfa_pkg::*;

	logic valid_s1;
	logic last_s1;
	logic [STATE_W-1:0] cur_s1;

	logic [STATE_W-1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic stopped_q;
	logic flags_q [NUM_STATES];

	logic commit;
	logic found;
	run_t walked;
	logic acc;

	assign s1.valid = valid_s1;
	assign s1.last = last_s1;
	assign commit = valid_s1 & advance;

	always_comb begin
		found = ~stopped_q & in_range(cur_s1) & rd.valid;
		walked.stopped = stopped_q | ~found;
		if (stopped_q) begin
			walked.state = state_q;
		end else if (found) begin
			walked.state = rd.next;
		end else begin
			walked.state = cur_s1;
		end
		if (found && (count_q < CNT_W'(MAX_LENGTH))) begin
			walked.count = count_q + 1'b1;
		end else begin
			walked.count = count_q;
		end

		acc = in_range(walked.state) & flags_q[walked.state[FLAG_AW-1:0]];
		res.accepted = acc;
		res.match_length = acc ? LEN_W'(walked.count) : '0;

		// run state as it stands once this cycle's byte is retired
		if (commit && last_s1) begin
			fwd.state = start_state;
			fwd.count = '0;
			fwd.stopped = 1'b0;
		end else if (commit) begin
			fwd = walked;
		end else begin
			fwd.state = state_q;
			fwd.count = count_q;
			fwd.stopped = stopped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= '0;
			count_q <= '0;
			stopped_q <= 1'b0;
			for (int i = 0; i < NUM_STATES; i++) begin
				flags_q[i] <= 1'b0;
			end
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			state_q <= fwd.state;
			count_q <= fwd.count;
			stopped_q <= fwd.stopped;
			if (flag_we && in_range(flag_idx)) begin
				flags_q[flag_idx[FLAG_AW-1:0]] <= flag_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= issue_last;
			cur_s1 <= issue_cur;
		end
	end

endmodule

[rtl/dfa_prefix_matcher.sv]
// top level of the table-driven prefix matcher
// Table-driven automaton that matches a prefix of each byte string. Input
// transactions either write one transition into the table, set or clear a
// state's accepting flag, or feed one string byte; the final byte of a string
// gives one result transaction with the accept decision and consumed length.
// Input transactions can follow one another back to back while the table is not
// being cleared and the resolve stage is not stalled: the next-state entry read
// for one byte comes straight out of the table memory's read register and steers
// the address of the following byte's lookup. A result leaves from an output
// register once its last byte passes the resolve stage, so input keeps flowing
// while a result waits. After reset the block clears the 4096-entry transition
// table, one entry per cycle, and takes no input transaction until that pass
// ends; the start state register can be written at any time.
module dfa_prefix_matcher (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel: start state
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dfa_pkg::STATE_W-1:0]  cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [dfa_pkg::STATE_W-1:0]  state_index,
	input  logic [dfa_pkg::SYM_W-1:0]    symbol,
	input  logic [dfa_pkg::STATE_W-1:0]  target_state,
	input  logic                         entry_valid,
	input  logic                         last,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accepted,
	output logic [dfa_pkg::LEN_W-1:0]    match_length
);
	import dfa_pkg::*;

	logic [STATE_W-1:0] start_q;
	logic out_valid_q;
	result_t out_q;

	logic mem_busy;
	mem_req_t req;
	edge_t rdata;
	run_t fwd;
	s1_stat_t s1;
	result_t res;

	logic take;
	logic feed;
	logic advance;
	logic [STATE_W-1:0] cur0;

	// start state register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid) begin
			start_q <= cfg_data;
		end
	end

	// the resolve stage stalls only when it holds a last byte and the
	// output register is still occupied
	assign advance = ~(s1.valid & s1.last) | ~out_valid_q | out_ready;
	assign in_ready = ~mem_busy & (~s1.valid | advance);
	assign take = in_valid & in_ready;
	assign feed = take & (op == OP_FEED);

	// a fresh string reads the start state directly, otherwise use the
	// state forwarded from the byte being resolved this cycle
	assign cur0 = (fwd.count == '0) ? start_q : fwd.state;

	always_comb begin
		req.we = (op == OP_WR_EDGE);
		req.en = feed | (take & req.we & in_range(state_index));
		req.addr = req.we ? tab_addr(state_index, symbol) : tab_addr(cur0, symbol);
		req.wdata.valid = entry_valid;
		req.wdata.next = target_state;
	end

	dfa_trans_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata),
		.busy   (mem_busy)
	);

	dfa_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (feed),
		.issue_last  (last),
		.issue_cur   (cur0),
		.advance     (advance),
		.flag_we     (take & (op == OP_WR_ACCEPT)),
		.flag_idx    (state_index),
		.flag_val    (entry_valid),
		.start_state (start_q),
		.rd          (rdata),
		.fwd         (fwd),
		.s1          (s1),
		.res         (res)
	);

	// output register holds a result until its transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1.valid && s1.last && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1.valid && s1.last && advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = out_q.accepted;
	assign match_length = out_q.match_length;

`ifndef SYNTHESIS
	// no lookup or table write slips in during the clearing pass
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !in_ready)
		else $error("input taken while transition table is being cleared");

	// every accepted byte reaches the resolve stage next cycle
	a_feed_s1: assert property (@(posedge clk) disable iff (!arst_n)
		feed |=> s1.valid)
		else $error("fed byte lost before resolve stage");

	// a rejected run always reports a zero length
	a_reject_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted || (match_length == '0)))
		else $error("rejected result with non-zero length");

	// consumed count saturates
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fwd.count) <= MAX_LENGTH)
		else $error("consumed count beyond saturation limit");
`endif

endmodule

[tb/dfa_prefix_matcher_tb.sv]
// self-checking testbench for the table-driven prefix matcher
`timescale 1ns / 100ps

module dfa_prefix_matcher_tb;
	import dfa_pkg::*;

	// the encoding left unused by the block, which must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one input transaction, field for field as it goes onto the ports
	typedef struct packed {
		logic [1:0]         op;
		logic [STATE_W-1:0] sidx;
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] tgt;
		logic               ev;
		logic               lst;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [STATE_W-1:0] cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	req_t               on_bus = '0;
	logic [1:0]         op;
	logic [STATE_W-1:0] state_index;
	logic [SYM_W-1:0]   symbol;
	logic [STATE_W-1:0] target_state;
	logic               entry_valid;
	logic               last;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               accepted;
	logic [LEN_W-1:0]   match_length;

	assign op = on_bus.op;
	assign state_index = on_bus.sidx;
	assign symbol = on_bus.sym;
	assign target_state = on_bus.tgt;
	assign entry_valid = on_bus.ev;
	assign last = on_bus.lst;

	dfa_prefix_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.state_index(state_index),
		.symbol(symbol),
		.target_state(target_state),
		.entry_valid(entry_valid),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.match_length(match_length)
	);

	always #6 clk = ~clk;

	// stimulus waiting to go out, and the verdicts still owed by the block
	req_t    pending [$];
	result_t expected_verdicts [$];
	int      fail_count = 0;

	// side conditions shared between the sequencer and the two handshake processes
	bit calm = 1'b0;    // no random gaps on either side while set
	bit squeeze = 1'b0; // asks the receiver for one long hold-off

	// private copy of the automaton: tables, start register and the running string
	edge_t            edge_mem [TAB_DEPTH];
	logic             accept_mem [NUM_STATES];
	logic [STATE_W-1:0] start_cfg = '0;
	logic [STATE_W-1:0] walk_state = '0;
	logic [LEN_W-1:0]   walk_len = '0;
	logic               walk_halted = 1'b0;

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_count++;
	endtask

	// append one transaction to the stimulus queue
	function automatic void enqueue(input req_t it);
		pending = {pending, it};
	endfunction

	// most gaps short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 30);
	endfunction

	// advance the private automaton by one accepted transaction
	function automatic void walk_matcher(input req_t it);
		logic [STATE_W-1:0] s;
		logic               hit;
		result_t            v;
		case (it.op)
			OP_WR_EDGE: begin
				// a repeated write simply overwrites the entry
				if (int'(it.sidx) < NUM_STATES) begin
					edge_mem[{it.sidx, it.sym}].valid = it.ev;
					edge_mem[{it.sidx, it.sym}].next = it.tgt;
				end
			end
			OP_WR_ACCEPT: begin
				if (int'(it.sidx) < NUM_STATES)
					accept_mem[it.sidx] = it.ev;
			end
			OP_FEED: begin
				if (!walk_halted) begin
					// at the head of a string the start register is read afresh
					s = (walk_len == 0) ? start_cfg : walk_state;
					hit = 1'b0;
					if (int'(s) < NUM_STATES && edge_mem[{s, it.sym}].valid) begin
						hit = 1'b1;
						s = edge_mem[{s, it.sym}].next;
						if (int'(walk_len) < MAX_LENGTH)
							walk_len = walk_len + 1'b1;
					end
					walk_state = s;
					if (!hit)
						walk_halted = 1'b1;
				end
				if (it.lst) begin
					// accept decision taken from the flag of the frozen state right now
					v.accepted = (int'(walk_state) < NUM_STATES) && accept_mem[walk_state];
					v.match_length = v.accepted ? walk_len : '0;
					expected_verdicts = {expected_verdicts, v};
					walk_state = start_cfg;
					walk_len = '0;
					walk_halted = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// transaction builders; fields the operation does not use carry noise
	function automatic req_t mk_edge(input logic [STATE_W-1:0] s, input logic [SYM_W-1:0] c,
			input logic [STATE_W-1:0] t, input logic v);
		req_t it;
		it = 20'($urandom);
		it.op = OP_WR_EDGE;
		it.sidx = s;
		it.sym = c;
		it.tgt = t;
		it.ev = v;
		return it;
	endfunction

	function automatic req_t mk_flag(input logic [STATE_W-1:0] s, input logic v);
		req_t it;
		it = 20'($urandom);
		it.op = OP_WR_ACCEPT;
		it.sidx = s;
		it.ev = v;
		return it;
	endfunction

	function automatic req_t mk_byte(input logic [SYM_W-1:0] c, input logic l);
		req_t it;
		it = 20'($urandom);
		it.op = OP_FEED;
		it.sym = c;
		it.lst = l;
		return it;
	endfunction

	function automatic req_t mk_noise();
		req_t it;
		it = 20'($urandom);
		it.op = OP_UNUSED;
		return it;
	endfunction

	// input driver: the model sees each transaction at the edge that accepts it
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				walk_matcher(on_bus);
			// a new transaction only once the current one has gone
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() != 0) begin
					on_bus <= pending.pop_front();
					in_valid <= 1'b1;
					gap_left <= calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	result_t want;
	logic    rdy_next;
	int      stall_left = 0;
	int      hold_left = 0;
	bit      squeeze_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending: accepted %b length %0d",
						accepted, match_length));
				end else begin
					want = expected_verdicts.pop_front();
					if (accepted !== want.accepted)
						flag_mismatch($sformatf("accepted is %b, expected %b",
							accepted, want.accepted));
					if (match_length !== want.match_length)
						flag_mismatch($sformatf("match_length is %0d, expected %0d",
							match_length, want.match_length));
				end
			end
			// long hold-off so that the block fills and stalls its input
			if (hold_left != 0) begin
				rdy_next = 1'b0;
				hold_left = hold_left - 1;
			end else if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left = 400;
				rdy_next = 1'b0;
			end else if (stall_left != 0) begin
				rdy_next = 1'b0;
				stall_left = stall_left - 1;
			end else if (calm) begin
				rdy_next = 1'b1;
			end else begin
				stall_left = pick_gap();
				rdy_next = (stall_left == 0);
				if (stall_left != 0)
					stall_left = stall_left - 1;
			end
			out_ready <= rdy_next;
		end
	end

	// start state write, only ever issued with the block idle
	task automatic set_start(input logic [STATE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		start_cfg = v;
		@(negedge clk);
	endtask

	// everything sent, every verdict back, then a wait for trailing table writes
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// generous overall limit
	initial begin
		#12_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int               ph, n, len, k, r, waited;
		logic [SYM_W-1:0] alpha [3];
		logic [SYM_W-1:0] c;
		logic [STATE_W-1:0] s;

		foreach (edge_mem[i])
			edge_mem[i] = '0;
		foreach (accept_mem[i])
			accept_mem[i] = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: nothing accepting yet, so the first string is refused
		enqueue(mk_byte(8'h00, 1'b1));
		// path 0 -A-> 1 -FF-> 15 with a self loop on 00
		enqueue(mk_edge(4'd0, 8'h41, 4'd1, 1'b1));
		enqueue(mk_edge(4'd1, 8'hFF, 4'd15, 1'b1));
		enqueue(mk_edge(4'd15, 8'h00, 4'd15, 1'b1));
		enqueue(mk_byte(8'h41, 1'b0));
		enqueue(mk_byte(8'hFF, 1'b0));
		enqueue(mk_byte(8'h00, 1'b1));
		// mark 15 accepting and repeat the same string
		enqueue(mk_flag(4'd15, 1'b1));
		enqueue(mk_byte(8'h41, 1'b0));
		enqueue(mk_byte(8'hFF, 1'b0));
		enqueue(mk_byte(8'h00, 1'b1));
		// stop early in state 1, flag it during the ignored tail
		enqueue(mk_byte(8'h41, 1'b0));
		enqueue(mk_byte(8'h42, 1'b0));
		enqueue(mk_flag(4'd1, 1'b1));
		enqueue(mk_byte(8'h41, 1'b1));
		// unused operation must leave no trace
		enqueue(mk_noise());
		// removing an edge stops the string at its first byte
		enqueue(mk_edge(4'd0, 8'h41, 4'd1, 1'b0));
		enqueue(mk_byte(8'h41, 1'b1));
		// table writes in the middle of a string steer the bytes after them
		enqueue(mk_edge(4'd0, 8'h41, 4'd1, 1'b1));
		enqueue(mk_byte(8'h41, 1'b0));
		enqueue(mk_edge(4'd1, 8'h10, 4'd15, 1'b1));
		enqueue(mk_byte(8'h10, 1'b0));
		enqueue(mk_byte(8'h00, 1'b1));
		wait_idle();

		// random phases, each with its own start state and small alphabet
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_start(4'd15);
				1: set_start(4'd0);
				default: set_start(4'($urandom));
			endcase
			calm = (ph == 1);
			if (ph == 1)
				squeeze = 1'b1;
			for (k = 0; k < 3; k++)
				alpha[k] = 8'($urandom);
			if (ph == 3) begin
				alpha[0] = 8'h00;
				alpha[1] = 8'hFF;
			end
			// mostly complete table over the alphabet, a few holes
			for (k = 0; k < NUM_STATES * 3; k++)
				enqueue(mk_edge(4'(k / 3), alpha[k % 3], 4'($urandom),
					$urandom_range(0, 9) != 0));
			for (k = 0; k < 6; k++)
				enqueue(mk_flag(4'($urandom), 1'($urandom)));
			n = 54;
			while (n < 155) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// well-formed string, mostly on the alphabet
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 10);
					for (k = 0; k < len; k++) begin
						case ($urandom_range(0, 24))
							0: enqueue(mk_edge(4'($urandom), alpha[$urandom_range(0, 2)],
								4'($urandom), $urandom_range(0, 3) != 0));
							1: enqueue(mk_flag(4'($urandom), 1'($urandom)));
							default: begin
							end
						endcase
						c = ($urandom_range(0, 12) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 2)];
						enqueue(mk_byte(c, k == len - 1));
						n++;
					end
				end else if (r < 88) begin
					c = ($urandom_range(0, 1) != 0) ? 8'($urandom) : alpha[$urandom_range(0, 2)];
					enqueue(mk_edge(4'($urandom), c, 4'($urandom), 1'($urandom)));
					n++;
				end else if (r < 94) begin
					enqueue(mk_flag(4'($urandom), 1'($urandom)));
					n++;
				end else if (r < 97) begin
					enqueue(mk_noise());
				end else begin
					// stray bytes off the alphabet
					enqueue(mk_byte(8'($urandom), 1'($urandom)));
					n++;
				end
			end
			// close any open string before the phase boundary
			enqueue(mk_byte(alpha[0], 1'b1));
			wait_idle();
			calm = 1'b0;
		end

		// one longer run round a self loop
		s = 4'($urandom);
		c = 8'($urandom);
		set_start(s);
		enqueue(mk_edge(s, c, s, 1'b1));
		enqueue(mk_flag(s, 1'b1));
		for (k = 0; k < 40; k++)
			enqueue(mk_byte(c, k == 39));

		// wind down: all stimulus out, then the last verdicts, with a bound
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid);
		waited = 0;
		while (expected_verdicts.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_verdicts.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
